@@ hw/rtl/rv32id_pkg.sv @@
// ----------------------------------------------------------------------------
// RV32I decoder package
// Shared types, opcode and function-field constants and the operation codes
// used by the instruction decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rv32id_pkg;

  localparam int unsigned InstrW    = 32;
  localparam int unsigned RegIdxW   = 5;
  localparam int unsigned OperW     = 6;
  localparam int unsigned OutTdataW = 56;

  // Major opcodes.
  localparam logic [6:0] OPC_R      = 7'b0110011;
  localparam logic [6:0] OPC_I      = 7'b0010011;
  localparam logic [6:0] OPC_LOAD   = 7'b0000011;
  localparam logic [6:0] OPC_STORE  = 7'b0100011;
  localparam logic [6:0] OPC_BRANCH = 7'b1100011;
  localparam logic [6:0] OPC_JAL    = 7'b1101111;
  localparam logic [6:0] OPC_JALR   = 7'b1100111;
  localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
  localparam logic [6:0] OPC_LUI    = 7'b0110111;

  // funct7 values.
  localparam logic [6:0] F7_BASE = 7'b0000000;
  localparam logic [6:0] F7_ALT  = 7'b0100000;

  // funct3 values for the ALU formats.
  localparam logic [2:0] F3_ADD_SUB = 3'd0;
  localparam logic [2:0] F3_SLL     = 3'd1;
  localparam logic [2:0] F3_SLT     = 3'd2;
  localparam logic [2:0] F3_SLTU    = 3'd3;
  localparam logic [2:0] F3_XOR     = 3'd4;
  localparam logic [2:0] F3_SHR     = 3'd5;
  localparam logic [2:0] F3_OR      = 3'd6;
  localparam logic [2:0] F3_AND     = 3'd7;

  // funct3 values for loads and stores.
  localparam logic [2:0] F3_BYTE  = 3'd0;
  localparam logic [2:0] F3_HALF  = 3'd1;
  localparam logic [2:0] F3_WORD  = 3'd2;
  localparam logic [2:0] F3_BYTEU = 3'd4;
  localparam logic [2:0] F3_HALFU = 3'd5;

  // funct3 values for branches.
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  // funct3 value for jalr.
  localparam logic [2:0] F3_JALR = 3'd0;

  typedef enum logic [OperW-1:0] {
    OP_ADD   = 6'd0,
    OP_SUB   = 6'd1,
    OP_SLL   = 6'd2,
    OP_SLT   = 6'd3,
    OP_SLTU  = 6'd4,
    OP_XOR   = 6'd5,
    OP_SRL   = 6'd6,
    OP_SRA   = 6'd7,
    OP_OR    = 6'd8,
    OP_AND   = 6'd9,
    OP_ADDI  = 6'd10,
    OP_SLTI  = 6'd11,
    OP_SLTIU = 6'd12,
    OP_XORI  = 6'd13,
    OP_ORI   = 6'd14,
    OP_ANDI  = 6'd15,
    OP_SLLI  = 6'd16,
    OP_SRLI  = 6'd17,
    OP_SRAI  = 6'd18,
    OP_LB    = 6'd19,
    OP_LH    = 6'd20,
    OP_LW    = 6'd21,
    OP_LBU   = 6'd22,
    OP_LHU   = 6'd23,
    OP_SB    = 6'd24,
    OP_SH    = 6'd25,
    OP_SW    = 6'd26,
    OP_BEQ   = 6'd27,
    OP_BNE   = 6'd28,
    OP_BLT   = 6'd29,
    OP_BGE   = 6'd30,
    OP_BLTU  = 6'd31,
    OP_BGEU  = 6'd32,
    OP_JAL   = 6'd33,
    OP_JALR  = 6'd34,
    OP_AUIPC = 6'd35,
    OP_LUI   = 6'd36
  } oper_e;

  typedef struct packed {
    oper_e              operation;
    logic [RegIdxW-1:0] dest_reg;
    logic [RegIdxW-1:0] src1_reg;
    logic [RegIdxW-1:0] src2_reg;
    logic signed [31:0] immediate;
    logic               illegal;
  } dec_result_t;

endpackage

`default_nettype wire

@@ hw/rtl/rv32id_decode.sv @@
// ----------------------------------------------------------------------------
// RV32I decode logic
// Combinational decode of one instruction word into operation code, register
// numbers, immediate and illegal flag.
// ----------------------------------------------------------------------------
`default_nettype none

module rv32id_decode (
  input  wire logic [rv32id_pkg::InstrW-1:0] instr_i,
  output rv32id_pkg::dec_result_t            result_o
);

  logic [6:0]  opc;
  logic [4:0]  rd;
  logic [2:0]  f3;
  logic [4:0]  rs1;
  logic [4:0]  rs2;
  logic [6:0]  f7;
  logic [31:0] imm_i;
  logic [31:0] imm_s;
  logic [31:0] imm_b;
  logic [31:0] imm_j;
  logic [31:0] imm_u;
  logic [31:0] imm_sh;

  rv32id_pkg::oper_e op;
  logic              legal;
  logic [4:0]        d;
  logic [4:0]        s1;
  logic [4:0]        s2;
  logic [31:0]       imm;

  assign opc = instr_i[6:0];
  assign rd  = instr_i[11:7];
  assign f3  = instr_i[14:12];
  assign rs1 = instr_i[19:15];
  assign rs2 = instr_i[24:20];
  assign f7  = instr_i[31:25];

  assign imm_i  = {{20{instr_i[31]}}, instr_i[31:20]};
  assign imm_s  = {{20{instr_i[31]}}, instr_i[31:25], instr_i[11:7]};
  assign imm_b  = {{19{instr_i[31]}}, instr_i[31], instr_i[7], instr_i[30:25],
                   instr_i[11:8], 1'b0};
  assign imm_j  = {{11{instr_i[31]}}, instr_i[31], instr_i[19:12], instr_i[20],
                   instr_i[30:21], 1'b0};
  assign imm_u  = {instr_i[31:12], 12'b0};
  assign imm_sh = {27'b0, instr_i[24:20]};

  always_comb begin
    op    = rv32id_pkg::OP_ADD;
    legal = 1'b0;
    d     = '0;
    s1    = '0;
    s2    = '0;
    imm   = '0;
    case (opc)
      rv32id_pkg::OPC_R: begin
        d  = rd;
        s1 = rs1;
        s2 = rs2;
        if (f7 == rv32id_pkg::F7_BASE) begin
          legal = 1'b1;
          case (f3)
            rv32id_pkg::F3_ADD_SUB: op = rv32id_pkg::OP_ADD;
            rv32id_pkg::F3_SLL:     op = rv32id_pkg::OP_SLL;
            rv32id_pkg::F3_SLT:     op = rv32id_pkg::OP_SLT;
            rv32id_pkg::F3_SLTU:    op = rv32id_pkg::OP_SLTU;
            rv32id_pkg::F3_XOR:     op = rv32id_pkg::OP_XOR;
            rv32id_pkg::F3_SHR:     op = rv32id_pkg::OP_SRL;
            rv32id_pkg::F3_OR:      op = rv32id_pkg::OP_OR;
            default:                op = rv32id_pkg::OP_AND;
          endcase
        end else if (f7 == rv32id_pkg::F7_ALT && f3 == rv32id_pkg::F3_ADD_SUB) begin
          legal = 1'b1;
          op    = rv32id_pkg::OP_SUB;
        end else if (f7 == rv32id_pkg::F7_ALT && f3 == rv32id_pkg::F3_SHR) begin
          legal = 1'b1;
          op    = rv32id_pkg::OP_SRA;
        end
      end
      rv32id_pkg::OPC_I: begin
        d  = rd;
        s1 = rs1;
        case (f3)
          rv32id_pkg::F3_SLL: begin
            imm   = imm_sh;
            op    = rv32id_pkg::OP_SLLI;
            legal = (f7 == rv32id_pkg::F7_BASE);
          end
          rv32id_pkg::F3_SHR: begin
            imm   = imm_sh;
            op    = (f7 == rv32id_pkg::F7_ALT) ? rv32id_pkg::OP_SRAI : rv32id_pkg::OP_SRLI;
            legal = (f7 == rv32id_pkg::F7_BASE) || (f7 == rv32id_pkg::F7_ALT);
          end
          rv32id_pkg::F3_ADD_SUB: begin
            imm = imm_i; op = rv32id_pkg::OP_ADDI; legal = 1'b1;
          end
          rv32id_pkg::F3_SLT: begin
            imm = imm_i; op = rv32id_pkg::OP_SLTI; legal = 1'b1;
          end
          rv32id_pkg::F3_SLTU: begin
            imm = imm_i; op = rv32id_pkg::OP_SLTIU; legal = 1'b1;
          end
          rv32id_pkg::F3_XOR: begin
            imm = imm_i; op = rv32id_pkg::OP_XORI; legal = 1'b1;
          end
          rv32id_pkg::F3_OR: begin
            imm = imm_i; op = rv32id_pkg::OP_ORI; legal = 1'b1;
          end
          default: begin
            imm = imm_i; op = rv32id_pkg::OP_ANDI; legal = 1'b1;
          end
        endcase
      end
      rv32id_pkg::OPC_LOAD: begin
        d     = rd;
        s1    = rs1;
        imm   = imm_i;
        legal = 1'b1;
        case (f3)
          rv32id_pkg::F3_BYTE:  op = rv32id_pkg::OP_LB;
          rv32id_pkg::F3_HALF:  op = rv32id_pkg::OP_LH;
          rv32id_pkg::F3_WORD:  op = rv32id_pkg::OP_LW;
          rv32id_pkg::F3_BYTEU: op = rv32id_pkg::OP_LBU;
          rv32id_pkg::F3_HALFU: op = rv32id_pkg::OP_LHU;
          default:              legal = 1'b0;
        endcase
      end
      rv32id_pkg::OPC_STORE: begin
        s1    = rs1;
        s2    = rs2;
        imm   = imm_s;
        legal = 1'b1;
        case (f3)
          rv32id_pkg::F3_BYTE: op = rv32id_pkg::OP_SB;
          rv32id_pkg::F3_HALF: op = rv32id_pkg::OP_SH;
          rv32id_pkg::F3_WORD: op = rv32id_pkg::OP_SW;
          default:             legal = 1'b0;
        endcase
      end
      rv32id_pkg::OPC_BRANCH: begin
        s1    = rs1;
        s2    = rs2;
        imm   = imm_b;
        legal = 1'b1;
        case (f3)
          rv32id_pkg::F3_BEQ:  op = rv32id_pkg::OP_BEQ;
          rv32id_pkg::F3_BNE:  op = rv32id_pkg::OP_BNE;
          rv32id_pkg::F3_BLT:  op = rv32id_pkg::OP_BLT;
          rv32id_pkg::F3_BGE:  op = rv32id_pkg::OP_BGE;
          rv32id_pkg::F3_BLTU: op = rv32id_pkg::OP_BLTU;
          rv32id_pkg::F3_BGEU: op = rv32id_pkg::OP_BGEU;
          default:             legal = 1'b0;
        endcase
      end
      rv32id_pkg::OPC_JAL: begin
        d     = rd;
        imm   = imm_j;
        op    = rv32id_pkg::OP_JAL;
        legal = 1'b1;
      end
      rv32id_pkg::OPC_JALR: begin
        d     = rd;
        s1    = rs1;
        imm   = imm_i;
        op    = rv32id_pkg::OP_JALR;
        legal = (f3 == rv32id_pkg::F3_JALR);
      end
      rv32id_pkg::OPC_AUIPC: begin
        d     = rd;
        imm   = imm_u;
        op    = rv32id_pkg::OP_AUIPC;
        legal = 1'b1;
      end
      rv32id_pkg::OPC_LUI: begin
        d     = rd;
        imm   = imm_u;
        op    = rv32id_pkg::OP_LUI;
        legal = 1'b1;
      end
      default: begin
        legal = 1'b0;
      end
    endcase
  end

  // An illegal word reports all fields as zero, except the illegal flag, which is set.
  always_comb begin
    if (legal) begin
      result_o.operation = op;
      result_o.dest_reg  = d;
      result_o.src1_reg  = s1;
      result_o.src2_reg  = s2;
      result_o.immediate = imm;
      result_o.illegal   = 1'b0;
    end else begin
      result_o.operation = rv32id_pkg::OP_ADD;
      result_o.dest_reg  = '0;
      result_o.src1_reg  = '0;
      result_o.src2_reg  = '0;
      result_o.immediate = '0;
      result_o.illegal   = 1'b1;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/rv32i_instruction_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// Pipeline: an input transaction is captured in the input register, decoded
// combinationally and held in the result register until the output takes it.
// Throughput: one instruction per cycle while the output is not stalled, set by
// the input and result registers around the combinational decode logic.
// Reset: asynchronous active-low reset empties both pipeline registers.
// ----------------------------------------------------------------------------
// RV32I instruction decoder unit
// Registered stream wrapper around the combinational RV32I decode logic.
// ----------------------------------------------------------------------------
`default_nettype none

module rv32i_instruction_decoder_unit (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // tdata: instruction_word[31:0]
  input  wire logic [rv32id_pkg::InstrW-1:0]       s_axis_tdata,
  input  wire logic                                s_axis_tvalid,
  output      logic                                s_axis_tready,
  // tdata: operation[5:0], dest_reg[10:6], src1_reg[15:11], src2_reg[20:16],
  //        immediate[52:21], zero pad[55:53]
  output      logic [rv32id_pkg::OutTdataW-1:0]    m_axis_tdata,
  // tuser: illegal[0]
  output      logic                                m_axis_tuser,
  output      logic                                m_axis_tvalid,
  input  wire logic                                m_axis_tready
);

  logic                            in_valid_q;
  logic                            in_valid_d;
  logic [rv32id_pkg::InstrW-1:0]   in_word_q;
  logic                            out_valid_q;
  logic                            out_valid_d;
  rv32id_pkg::dec_result_t         res_q;
  rv32id_pkg::dec_result_t         dec_res;
  logic                            out_free;
  logic                            advance;
  logic                            in_take;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  assign in_valid_d  = in_take || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && !m_axis_tready);

  rv32id_decode u_decode (
    .instr_i  (in_word_q),
    .result_o (dec_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_word_q <= s_axis_tdata;
    end
    if (advance) begin
      res_q <= dec_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = res_q.illegal;
  assign m_axis_tdata  = {3'b000, res_q.immediate, res_q.src2_reg, res_q.src1_reg,
                          res_q.dest_reg, res_q.operation};

endmodule

`default_nettype wire
